### hdl/lzse_pkg.sv
package lzse_pkg;

  localparam int DICT_SIZE  = 4096;
  localparam int CODE_W     = $clog2(DICT_SIZE);
  localparam int COUNT_W    = CODE_W + 1;
  localparam int BYTE_W     = 8;
  localparam int KEY_W      = CODE_W + BYTE_W;

  // The dictionary is split over a row of cells; code c lives in cell
  // c mod NUM_CELLS at bank address c / NUM_CELLS.
  localparam int NUM_CELLS  = 16;
  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int BANK_DEPTH = DICT_SIZE / NUM_CELLS;
  localparam int ADDR_W     = $clog2(BANK_DEPTH);

  localparam logic [CODE_W-1:0] TOP_CODE       = CODE_W'(DICT_SIZE - 1);
  localparam logic [CODE_W-1:0] DICT_LIMIT_RST = 12'd4095;

  // Search word that travels down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic              hit;
    logic [CODE_W-1:0] code;
  } tok_t;

  // Dictionary insert, seen by every cell.
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  key;
  } wr_t;

endpackage

### hdl/lzse_if.sv
interface lzse_in_if import lzse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lzse_out_if import lzse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] out_index;
  logic [BYTE_W-1:0] out_char;
  logic              has_char;
  logic              last_pair;

  modport source (output valid, output out_index, output out_char, output has_char,
                  output last_pair, input ready);
  modport sink   (input valid, input out_index, input out_char, input has_char,
                  input last_pair, output ready);
endinterface

interface lzse_cfg_if import lzse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] dict_limit;

  modport source (output valid, output dict_limit, input ready);
  modport sink   (input valid, input dict_limit, output ready);
endinterface

### hdl/lzse_cell.sv
module lzse_cell import lzse_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [CELL_W-1:0]  idx,
  input  logic [COUNT_W-1:0] fill,
  input  wr_t                wr,
  input  tok_t               tok_in,
  output tok_t               tok_out
);

  logic [KEY_W-1:0] mem [BANK_DEPTH];
  logic [KEY_W-1:0] rdata;
  tok_t             tok_q;
  logic [CODE_W-1:0] code_here;
  logic             match;

  always_ff @(posedge clk) begin
    if (wr.en && wr.code[CELL_W-1:0] == idx) begin
      mem[wr.code[CODE_W-1:CELL_W]] <= wr.key;
    end
    rdata <= mem[tok_in.addr];
  end

  // Only codes that were assigned in this stream count; stale bank contents
  // at or above the fill count are ignored.
  assign code_here = {tok_q.addr, idx};
  assign match = tok_q.valid && (rdata == tok_q.key) && (code_here != '0) &&
                 ({1'b0, code_here} < fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid   <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_q.valid   <= tok_in.valid;
      tok_out.valid <= tok_q.valid;
    end
    tok_q.last   <= tok_in.last;
    tok_q.addr   <= tok_in.addr;
    tok_q.key    <= tok_in.key;
    tok_q.hit    <= tok_in.hit;
    tok_q.code   <= tok_in.code;
    tok_out.last <= tok_q.last;
    tok_out.addr <= tok_q.addr;
    tok_out.key  <= tok_q.key;
    tok_out.hit  <= tok_q.hit | match;
    tok_out.code <= match ? code_here : tok_q.code;
  end

endmodule

### hdl/lz78_stream_encoder.sv
// A byte is searched for by scanning bank addresses 0 to (next_code - 1) / 16, one bank
// address per cycle, through the row of 16 cells, each with two registers.
// A new byte is accepted only once the previous one is done, also while its pair waits.
// Reset (synchronous, active high) empties the dictionary by its fill count,
// sets dict_limit to 4095 and clears the output valid flag; no clearing pass is needed.
module lz78_stream_encoder import lzse_pkg::*; (
  input logic       clk,
  input logic       rst,
  lzse_in_if.sink   bytes,
  lzse_out_if.source pairs,
  lzse_cfg_if.sink  cfg
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]         state;
  logic [CODE_W-1:0]  limit;
  logic [CODE_W-1:0]  phrase_code;
  logic [COUNT_W-1:0] next_code;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;
  logic [ADDR_W-1:0]  scan_addr;
  logic [ADDR_W-1:0]  scan_top;
  logic               hit_found;
  logic [CODE_W-1:0]  hit_code;
  logic               out_valid;

  tok_t               chain [NUM_CELLS+1];
  wr_t                wr;
  logic [CODE_W-1:0]  eff_limit;
  logic [COUNT_W-1:0] code_dec;
  logic               accept;
  logic               need_out;
  logic               slot_free;
  logic               finish;
  logic               can_insert;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = (state == S_IDLE);
  assign accept      = bytes.valid && bytes.ready;
  assign pairs.valid = out_valid;

  assign eff_limit  = (limit < TOP_CODE) ? limit : TOP_CODE;
  assign can_insert = (next_code <= {1'b0, eff_limit});
  assign code_dec   = next_code - COUNT_W'(1);

  assign need_out  = !hit_found || cur_last;
  assign slot_free = !out_valid || pairs.ready;
  assign finish    = (state == S_FINISH) && (!need_out || slot_free);

  always_comb begin
    chain[0].valid = (state == S_SCAN);
    chain[0].last  = (scan_addr == scan_top);
    chain[0].addr  = scan_addr;
    chain[0].key   = {phrase_code, cur_byte};
    chain[0].hit   = 1'b0;
    chain[0].code  = '0;
  end

  always_comb begin
    wr.en   = finish && !hit_found && can_insert;
    wr.code = next_code[CODE_W-1:0];
    wr.key  = {phrase_code, cur_byte};
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    lzse_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (CELL_W'(i)),
      .fill    (next_code),
      .wr      (wr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= DICT_LIMIT_RST;
    end else if (cfg.valid) begin
      limit <= cfg.dict_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phrase_code <= '0;
      next_code   <= COUNT_W'(1);
      hit_found   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_addr == scan_top) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (chain[NUM_CELLS].valid && chain[NUM_CELLS].last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (accept) begin
        hit_found <= 1'b0;
      end else if (chain[NUM_CELLS].valid && chain[NUM_CELLS].hit) begin
        hit_found <= 1'b1;
      end

      if (finish) begin
        if (cur_last) begin
          // Every stream starts from an empty dictionary.
          phrase_code <= '0;
          next_code   <= COUNT_W'(1);
        end else if (hit_found) begin
          phrase_code <= hit_code;
        end else begin
          phrase_code <= '0;
          if (can_insert) begin
            next_code <= next_code + COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte  <= bytes.in_byte;
      cur_last  <= bytes.end_of_stream;
      scan_addr <= '0;
      scan_top  <= code_dec[CODE_W-1:CELL_W];
    end else if (state == S_SCAN) begin
      scan_addr <= scan_addr + ADDR_W'(1);
    end
    if (chain[NUM_CELLS].valid && chain[NUM_CELLS].hit) begin
      hit_code <= chain[NUM_CELLS].code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && need_out) begin
      out_valid <= 1'b1;
    end else if (pairs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && need_out) begin
      pairs.out_index <= hit_found ? hit_code : phrase_code;
      pairs.out_char  <= hit_found ? '0 : cur_byte;
      pairs.has_char  <= !hit_found;
      pairs.last_pair <= cur_last;
    end
  end

  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_code != '0)
    else $error("fill count reached zero");

  a_no_stray_token: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !chain[NUM_CELLS].valid)
    else $error("search word left the cell row while idle");

  a_insert_on_miss: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (!hit_found && state == S_FINISH))
    else $error("dictionary insert after a match");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN && scan_addr == '0))
    else $error("accepted byte did not start a scan");

  a_pair_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    (finish && need_out) |-> slot_free)
    else $error("pending pair overwritten");

endmodule

### tb/tb_lz78_stream_encoder.sv
`timescale 1ns / 100ps

module tb_lz78_stream_encoder import lzse_pkg::*; ();

  localparam int RANDOM_ITEMS  = 1050;
  localparam int SETTLE_CYCLES = 320;   // above the worst byte latency
  localparam int LONG_HOLD     = 1500;
  localparam int HOLD_AT_PAIR  = 150;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              eos;
  } byte_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] char_val;
    logic              has_char;
    logic              last;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzse_in_if  byte_ch ();
  lzse_out_if pair_ch ();
  lzse_cfg_if cfg_ch ();

  lz78_stream_encoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .pairs (pair_ch),
    .cfg   (cfg_ch)
  );

  always #4 clk = ~clk;

  // Predictor state: phrases are looked up by their (prefix code, byte) key.
  logic [CODE_W-1:0]  phrase_book [bit [KEY_W-1:0]];
  logic [CODE_W-1:0]  phrase_code = '0;
  logic [COUNT_W-1:0] next_code = COUNT_W'(1);
  logic [CODE_W-1:0]  dict_limit_cur = DICT_LIMIT_RST;

  byte_item_t pending_bytes [$];
  pair_t      expected_pairs [$];
  byte_item_t offered;
  int         items_queued = 0;
  int         items_accepted = 0;
  int         pairs_seen = 0;
  int         mismatch_count = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          stall_mode = 0;
  int unsigned rx_cycle = 0;

  function automatic void encode_byte(input byte_item_t it);
    bit [KEY_W-1:0]    key;
    logic [CODE_W-1:0] eff_limit;
    pair_t             p;
    key = {phrase_code, it.value};
    eff_limit = (dict_limit_cur < TOP_CODE) ? dict_limit_cur : TOP_CODE;
    if (phrase_book.exists(key)) begin
      phrase_code = phrase_book[key];
      if (it.eos) begin
        p = '{code: phrase_code, char_val: '0, has_char: 1'b0, last: 1'b1};
        expected_pairs.push_back(p);
      end
    end else begin
      p = '{code: phrase_code, char_val: it.value, has_char: 1'b1, last: it.eos};
      expected_pairs.push_back(p);
      // Once the limit is reached the dictionary freezes; the pair still goes out.
      if (next_code <= {1'b0, eff_limit}) begin
        phrase_book[key] = next_code[CODE_W-1:0];
        next_code++;
      end
      phrase_code = '0;
    end
    if (it.eos) begin
      phrase_book.delete();
      phrase_code = '0;
      next_code = COUNT_W'(1);
    end
  endfunction

  // Sender: bursts of words with random gaps in between.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        encode_byte(offered);
        items_accepted++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          offered = pending_bytes.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.in_byte <= offered.value;
          byte_ch.end_of_stream <= offered.eos;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word and stalls on a pattern that changes mode now and then.
  always @(posedge clk) begin
    if (rst) begin
      pair_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (pair_ch.valid && pair_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no pair, got index=%0d char=%02h has_char=%0b last=%0b",
                   $time, pair_ch.out_index, pair_ch.out_char, pair_ch.has_char,
                   pair_ch.last_pair);
        end else begin
          if (pair_ch.out_index !== expected_pairs[0].code ||
              pair_ch.out_char !== expected_pairs[0].char_val ||
              pair_ch.has_char !== expected_pairs[0].has_char ||
              pair_ch.last_pair !== expected_pairs[0].last) begin
            mismatch_count++;
            $display("%0t: expected index=%0d char=%02h has_char=%0b last=%0b,",
                     $time, expected_pairs[0].code, expected_pairs[0].char_val,
                     expected_pairs[0].has_char, expected_pairs[0].last,
                     " got index=%0d char=%02h has_char=%0b last=%0b",
                     pair_ch.out_index, pair_ch.out_char, pair_ch.has_char,
                     pair_ch.last_pair);
          end
          void'(expected_pairs.pop_front());
        end
        pairs_seen++;
        // One long hold-off so the block fills up and pushes back on its input.
        if (pairs_seen == HOLD_AT_PAIR)
          hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pair_ch.ready <= 1'b0;
      end else begin
        unique case (stall_mode)
          0: pair_ch.ready <= 1'b1;
          1: pair_ch.ready <= 1'($urandom_range(0, 1));
          2: pair_ch.ready <= (rx_cycle % 4) == 0;
          default: pair_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] v, input logic eos);
    byte_item_t it;
    it = '{value: v, eos: eos};
    pending_bytes.push_back(it);
    items_queued++;
  endtask

  // A byte that matches makes no pair, so the block may still be busy after the last pair.
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_pairs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CODE_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.dict_limit <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    dict_limit_cur = v;
  endtask

  task automatic push_stream(input int len, input int alpha);
    logic [BYTE_W-1:0] symbols [16];
    int                r;
    foreach (symbols[k]) symbols[k] = $urandom_range(0, 255);
    // Most streams close with their last byte; the rest run on into the next one.
    r = $urandom_range(0, 9);
    for (int k = 0; k < len; k++) begin
      push_byte((alpha > 16) ? BYTE_W'($urandom_range(0, 255))
                             : symbols[$urandom_range(0, alpha - 1)],
                (k == len - 1) && (r != 0));
    end
  endtask

  function automatic logic [CODE_W-1:0] pick_limit();
    logic [CODE_W-1:0] choices [10];
    choices = '{12'd1, 12'd2, 12'd3, 12'd15, 12'd16, 12'd17, 12'd255, 12'd4094,
                12'd4095, 12'd0};
    choices[9] = $urandom_range(1, 4095);
    return choices[$urandom_range(0, 9)];
  endfunction

  initial begin
    int target;
    int r;
    int len;
    int alpha;
    byte_ch.valid = 1'b0;
    byte_ch.in_byte = '0;
    byte_ch.end_of_stream = 1'b0;
    pair_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.dict_limit = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Default limit: single-byte stream, flush of a matched last byte, unmatched last byte.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // Limit zero: nothing is ever added, every byte goes out on its own.
    write_limit('0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    wait_idle();

    // Limit one: the dictionary freezes after its first entry.
    write_limit(12'd1);
    repeat (4) push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b1);
    wait_idle();

    // Build a few entries, then lower the limit in the middle of the stream.
    write_limit(12'd4095);
    for (int k = 0; k < 7; k++)
      push_byte((k % 2 == 0) ? 8'h3C : 8'hC3, 1'b0);
    wait_idle();
    write_limit(12'd2);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b1);
    wait_idle();

    target = items_queued + RANDOM_ITEMS;
    while (items_queued < target) begin
      write_limit(pick_limit());
      r = items_queued + $urandom_range(50, 130);
      if (r > target) r = target;
      while (items_queued < r) begin
        len = $urandom_range(0, 99);
        if (len < 75) len = $urandom_range(1, 20);
        else if (len < 96) len = $urandom_range(21, 80);
        else len = $urandom_range(150, 300);
        if (len > target - items_queued) len = target - items_queued;
        alpha = $urandom_range(0, 99);
        if (alpha < 70) alpha = $urandom_range(1, 4);
        else if (alpha < 90) alpha = $urandom_range(5, 16);
        else alpha = 256;
        push_stream(len, alpha);
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("lz78_stream_encoder verification clean");
    end else begin
      $display("lz78_stream_encoder verification failed");
    end
    $finish;
  end

  initial begin
    #11_000_000;
    $display("lz78_stream_encoder verification failed");
    $finish;
  end

endmodule
